[rtl/resp_reply_stream_parser_unit_macros.svh]
// assertion helpers for the reply parser
`ifndef RESP_REPLY_STREAM_PARSER_UNIT_MACROS_SVH
`define RESP_REPLY_STREAM_PARSER_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RRSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RRSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/rrsp_pkg.sv]
`default_nettype none
package rrsp_pkg;
  localparam int unsigned MAX_DEPTH_DEF = 8;
  localparam int unsigned LEN_BITS_DEF  = 32;

  typedef enum logic [3:0] {
    EV_PAYLOAD    = 4'd0,
    EV_STATUS_END = 4'd1,
    EV_ERROR_END  = 4'd2,
    EV_BULK_END   = 4'd3,
    EV_NULL_BULK  = 4'd4,
    EV_INTEGER    = 4'd5,
    EV_ARRAY_HDR  = 4'd6,
    EV_PROTO_ERR  = 4'd7,
    EV_NULL_ARRAY = 4'd8
  } event_t;

  typedef enum logic [2:0] {
    PH_TYPE, PH_LINE, PH_LINE_CR, PH_NUM, PH_NUM_CR, PH_BODY, PH_POP, PH_OUT
  } phase_t;

  typedef enum logic [2:0] {
    K_STATUS, K_ERROR, K_INT, K_BULK, K_ARRAY
  } kind_t;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // controller to datapath
  typedef struct packed {
    logic   clr_elem;     // start a fresh element
    logic   set_neg;
    logic   acc_digit;    // accumulate one digit
    logic   len_inc;      // count a line byte
    logic   load_bulk;    // load body counter
    logic   body_dec;
    logic   push;         // push accumulator to stack
    logic   pop_dec;      // decrement top of stack
    logic   pop_level;    // drop one nesting level
    logic   latch_err;
  } rrsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic len_ovf;        // next digit would overflow length
    logic acc_zero;
    logic depth_full;
    logic nest_zero;
    logic top_one;        // top count is one
    logic body_last;      // counter at one
    logic body_payload;   // counter above two
  } rrsp_sts_t;
endpackage
`default_nettype wire

[rtl/rrsp_if.sv]
`default_nettype none
interface rrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rrsp_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        event_res;
  logic [7:0]        payload_byte;
  logic signed [63:0] number;
  logic [3:0]        level;
  logic              reply_done;
  modport source (output valid, output event_res, output payload_byte, output number,
                  output level, output reply_done, input ready);
  modport sink   (input valid, input event_res, input payload_byte, input number,
                  input level, input reply_done, output ready);
endinterface
`default_nettype wire

[rtl/rrsp_datapath.sv]
`default_nettype none
module rrsp_datapath #(
  parameter int unsigned MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = rrsp_pkg::LEN_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        din,
  input  wire rrsp_pkg::rrsp_cmd_t cmd,
  output rrsp_pkg::rrsp_sts_t    sts,
  output logic [63:0]            acc_o,
  output logic [63:0]            len_o,
  output logic [3:0]             nest_o
);
  localparam int unsigned NW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [63:0] LEN_MAX = 64'((65'd1 << LEN_BITS) - 65'd1);
  localparam logic [63:0] LEN_DIV = LEN_MAX / 64'd10;
  localparam logic [3:0]  LEN_REM = 4'(LEN_MAX % 64'd10);

  logic [63:0] acc_r, acc_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [LEN_BITS:0]   body_r, body_nxt;
  logic                neg_r, neg_nxt;
  logic [NW-1:0]       nest_r, nest_nxt;
  logic [31:0]         stk [MAX_DEPTH];
  logic [31:0]         top_w;
  logic [AW-1:0]       top_a;
  logic [3:0]          dig;

  assign dig   = din[3:0] - 4'(rrsp_pkg::CH_ZERO);
  assign top_a = AW'(nest_r - NW'(1));
  assign top_w = stk[top_a];

  // element registers
  always_comb begin
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    body_nxt = body_r;
    neg_nxt  = neg_r;
    nest_nxt = nest_r;
    if (cmd.clr_elem) begin
      acc_nxt = '0; len_nxt = '0; body_nxt = '0; neg_nxt = 1'b0;
    end
    if (cmd.set_neg) neg_nxt = 1'b1;
    if (cmd.acc_digit) acc_nxt = (acc_r << 3) + (acc_r << 1) + 64'(dig);
    if (cmd.len_inc && (len_r != '1)) len_nxt = len_r + LEN_BITS'(1);
    if (cmd.load_bulk) begin
      len_nxt  = LEN_BITS'(acc_r);
      body_nxt = (LEN_BITS+1)'(acc_r) + (LEN_BITS+1)'(2);
    end
    if (cmd.body_dec) body_nxt = body_r - (LEN_BITS+1)'(1);
    if (cmd.push) nest_nxt = nest_r + NW'(1);
    if (cmd.pop_level) nest_nxt = nest_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; len_r <= '0; body_r <= '0; neg_r <= 1'b0; nest_r <= '0;
    end else begin
      acc_r <= acc_nxt; len_r <= len_nxt; body_r <= body_nxt;
      neg_r <= neg_nxt; nest_r <= nest_nxt;
    end
  end

  // count stack
  always_ff @(posedge clk) begin
    if (cmd.push) stk[nest_r[AW-1:0]] <= acc_r[31:0];
    else if (cmd.pop_dec) stk[top_a] <= top_w - 32'd1;
  end

  always_comb begin
    sts.neg          = neg_r;
    sts.len_ovf      = (acc_r > LEN_DIV) || ((acc_r == LEN_DIV) && (dig > LEN_REM));
    sts.acc_zero     = (acc_r == '0);
    sts.depth_full   = (nest_r >= NW'(MAX_DEPTH));
    sts.nest_zero    = (nest_r == '0);
    sts.top_one      = (top_w == 32'd1);
    sts.body_last    = (body_r == (LEN_BITS+1)'(1));
    sts.body_payload = (body_r > (LEN_BITS+1)'(2));
  end

  assign acc_o  = neg_r ? (64'd0 - acc_r) : acc_r;
  assign len_o  = 64'(len_r);
  assign nest_o = 4'(nest_r);
endmodule
`default_nettype wire

[rtl/rrsp_ctrl.sv]
`default_nettype none
module rrsp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          din,
  input  wire rrsp_pkg::rrsp_sts_t sts,
  output rrsp_pkg::rrsp_cmd_t      cmd,
  input  wire logic [63:0]         acc,
  input  wire logic [63:0]         len,
  input  wire logic [3:0]          nest,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               ev_o,
  output logic [7:0]               pb_o,
  output logic [63:0]              num_o,
  output logic [3:0]               lvl_o,
  output logic                     done_o
);
  rrsp_pkg::phase_t st_r, st_nxt;
  rrsp_pkg::kind_t  kind_r, kind_nxt;
  logic err_r, err_nxt, ov_r, ov_nxt, pend_r, pend_nxt;
  logic [3:0] ev_r, ev_nxt, lvl_r, lvl_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic [63:0] num_r, num_nxt;
  logic done_r, done_nxt;
  logic acc_in;

  // output buffer free when empty or being drained; bytes after an error are dropped
  assign in_ready = (st_r != rrsp_pkg::PH_POP) && (!ov_r || out_ready);
  assign acc_in   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rrsp_pkg::PH_TYPE; kind_r <= rrsp_pkg::K_STATUS;
      err_r <= 1'b0; ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; kind_r <= kind_nxt;
      err_r <= err_nxt; ov_r <= ov_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt; pb_r <= pb_nxt; num_r <= num_nxt; lvl_r <= lvl_nxt; done_r <= done_nxt;
  end

  // next state, commands and result capture
  always_comb begin
    logic emit, fin;
    emit = 1'b0; fin = 1'b0;
    st_nxt = st_r; kind_nxt = kind_r; err_nxt = err_r;
    pend_nxt = pend_r;
    ev_nxt = ev_r; pb_nxt = pb_r; num_nxt = num_r; lvl_nxt = lvl_r; done_nxt = done_r;
    cmd = '0;
    if (acc_in && !err_r) begin
      pb_nxt = 8'd0; num_nxt = '0; lvl_nxt = nest; done_nxt = 1'b0;
      unique case (st_r)
        rrsp_pkg::PH_TYPE: begin
          cmd.clr_elem = 1'b1;
          unique case (din)
            rrsp_pkg::CH_PLUS: begin kind_nxt = rrsp_pkg::K_STATUS; st_nxt = rrsp_pkg::PH_LINE; end
            rrsp_pkg::CH_MINUS: begin kind_nxt = rrsp_pkg::K_ERROR; st_nxt = rrsp_pkg::PH_LINE; end
            rrsp_pkg::CH_COLON: begin kind_nxt = rrsp_pkg::K_INT; st_nxt = rrsp_pkg::PH_NUM; end
            rrsp_pkg::CH_DOLL: begin kind_nxt = rrsp_pkg::K_BULK; st_nxt = rrsp_pkg::PH_NUM; end
            rrsp_pkg::CH_STAR: begin kind_nxt = rrsp_pkg::K_ARRAY; st_nxt = rrsp_pkg::PH_NUM; end
            default: begin emit = 1'b1; ev_nxt = rrsp_pkg::EV_PROTO_ERR; err_nxt = 1'b1; end
          endcase
        end
        rrsp_pkg::PH_LINE, rrsp_pkg::PH_LINE_CR: begin
          if (st_r == rrsp_pkg::PH_LINE && din == rrsp_pkg::CH_CR) begin
            st_nxt = rrsp_pkg::PH_LINE_CR;
          end else if (st_r == rrsp_pkg::PH_LINE_CR && din == rrsp_pkg::CH_LF) begin
            emit = 1'b1; fin = 1'b1; num_nxt = len;
            ev_nxt = (kind_r == rrsp_pkg::K_ERROR) ? rrsp_pkg::EV_ERROR_END
                                                   : rrsp_pkg::EV_STATUS_END;
          end else begin
            cmd.len_inc = 1'b1; emit = 1'b1; ev_nxt = rrsp_pkg::EV_PAYLOAD; pb_nxt = din;
          end
        end
        rrsp_pkg::PH_NUM, rrsp_pkg::PH_NUM_CR: begin
          if (st_r == rrsp_pkg::PH_NUM && din == rrsp_pkg::CH_CR) begin
            st_nxt = rrsp_pkg::PH_NUM_CR;
          end else if (st_r == rrsp_pkg::PH_NUM_CR && din == rrsp_pkg::CH_LF) begin
            if (kind_r == rrsp_pkg::K_INT) begin
              emit = 1'b1; fin = 1'b1; ev_nxt = rrsp_pkg::EV_INTEGER; num_nxt = acc;
            end else if (kind_r == rrsp_pkg::K_BULK && !sts.neg) begin
              cmd.load_bulk = 1'b1; st_nxt = rrsp_pkg::PH_BODY;
            end else if (sts.neg) begin
              emit = 1'b1; fin = 1'b1; num_nxt = '1;
              ev_nxt = (kind_r == rrsp_pkg::K_BULK) ? rrsp_pkg::EV_NULL_BULK
                                                    : rrsp_pkg::EV_NULL_ARRAY;
            end else if (sts.acc_zero) begin
              emit = 1'b1; fin = 1'b1; ev_nxt = rrsp_pkg::EV_ARRAY_HDR;
            end else if (sts.depth_full) begin
              emit = 1'b1; ev_nxt = rrsp_pkg::EV_PROTO_ERR; err_nxt = 1'b1;
            end else begin
              emit = 1'b1; ev_nxt = rrsp_pkg::EV_ARRAY_HDR; num_nxt = acc;
              cmd.push = 1'b1; cmd.clr_elem = 1'b1; st_nxt = rrsp_pkg::PH_TYPE;
            end
          end else if (din == rrsp_pkg::CH_MINUS) begin
            cmd.set_neg = 1'b1;
          end else if (din >= rrsp_pkg::CH_ZERO && din <= rrsp_pkg::CH_NINE) begin
            if (kind_r != rrsp_pkg::K_INT && sts.len_ovf) begin
              emit = 1'b1; ev_nxt = rrsp_pkg::EV_PROTO_ERR; err_nxt = 1'b1;
            end else begin
              cmd.acc_digit = 1'b1;
            end
          end else begin
            emit = 1'b1; ev_nxt = rrsp_pkg::EV_PROTO_ERR; err_nxt = 1'b1;
          end
        end
        rrsp_pkg::PH_BODY: begin
          cmd.body_dec = 1'b1;
          if (sts.body_last) begin
            emit = 1'b1; fin = 1'b1; ev_nxt = rrsp_pkg::EV_BULK_END; num_nxt = len;
          end else if (sts.body_payload) begin
            emit = 1'b1; ev_nxt = rrsp_pkg::EV_PAYLOAD; pb_nxt = din;
          end
        end
        default: ;
      endcase
      // closing an element: hold the result while the stack unwinds
      if (fin) begin
        cmd.clr_elem = 1'b1; cmd.body_dec = 1'b0;
        st_nxt = rrsp_pkg::PH_TYPE;
        if (sts.nest_zero) begin
          done_nxt = 1'b1;
        end else begin
          emit = 1'b0; pend_nxt = 1'b1; st_nxt = rrsp_pkg::PH_POP;
        end
      end
    end else if (st_r == rrsp_pkg::PH_POP) begin
      // one stack level per cycle
      if (sts.nest_zero) begin
        done_nxt = 1'b1; st_nxt = rrsp_pkg::PH_TYPE; pend_nxt = 1'b0;
      end else if (!sts.top_one) begin
        cmd.pop_dec = 1'b1; st_nxt = rrsp_pkg::PH_TYPE; pend_nxt = 1'b0;
      end else begin
        cmd.pop_dec = 1'b1; cmd.pop_level = 1'b1;
      end
    end
    ov_nxt = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (emit || (st_r == rrsp_pkg::PH_POP && !pend_nxt)) ov_nxt = 1'b1;
  end

  assign out_valid = ov_r;
  assign ev_o   = ev_r;
  assign pb_o   = pb_r;
  assign num_o  = num_r;
  assign lvl_o  = lvl_r;
  assign done_o = done_r;
endmodule
`default_nettype wire

[rtl/resp_reply_stream_parser_unit.sv]
`default_nettype none
// byte-serial reply stream parser
// in channel: one byte of the reply stream per transfer (in_byte)
// out channel: one event per transfer: payload byte, string/integer end,
//   null bulk, array header, null array or protocol error, with number,
//   nesting level and reply_done set on the event that closes the reply
// timing: a result is registered, visible in the cycle after the byte that
//   causes it; an element inside an array holds its result while it walks the
//   count stack one level per cycle plus a closing step, input held off meanwhile
// throughput: one byte per cycle outside a stack walk while the result
//   register is free or drained in the same cycle; a held result blocks
//   the next byte
// reset: back to waiting for a type byte, no arrays open, error cleared
// after a protocol error every byte is still taken but dropped until reset
// when the receiver stalls, the pending result holds and in_ready drops
module resp_reply_stream_parser_unit #(
  parameter int unsigned MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = rrsp_pkg::LEN_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rrsp_in_if.sink   in_ch,
  rrsp_out_if.source out_ch
);
  rrsp_pkg::rrsp_cmd_t cmd;
  rrsp_pkg::rrsp_sts_t sts;
  logic [63:0] acc, len, num;
  logic [3:0]  nest;

  rrsp_datapath #(.MAX_DEPTH(MAX_DEPTH), .LEN_BITS(LEN_BITS)) u_dp (
    .clk, .rst_n, .din(in_ch.in_byte), .cmd, .sts,
    .acc_o(acc), .len_o(len), .nest_o(nest)
  );

  rrsp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .din(in_ch.in_byte), .sts, .cmd, .acc, .len, .nest,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .ev_o(out_ch.event_res), .pb_o(out_ch.payload_byte), .num_o(num),
    .lvl_o(out_ch.level), .done_o(out_ch.reply_done)
  );
  assign out_ch.number = signed'(num);
endmodule
`default_nettype wire

[rtl/rrsp_checker.sv]
`default_nettype none
`include "resp_reply_stream_parser_unit_macros.svh"
module rrsp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] ev,
  input wire logic       done
);
  // once an error event is taken nothing else comes out
  `RRSP_ASSERT_NXT(a_err_stops, clk, rst_n, out_valid && out_ready && ev == rrsp_pkg::EV_PROTO_ERR, !out_valid)
  // a stalled result holds
  `RRSP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(ev))
  // payload never completes a reply
  `RRSP_ASSERT_IMP(a_pay_done, clk, rst_n, out_valid && ev == rrsp_pkg::EV_PAYLOAD, !done)
  // a held result blocks input
  `RRSP_ASSERT_IMP(a_block, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind resp_reply_stream_parser_unit rrsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .ev(out_ch.event_res),
  .done(out_ch.reply_done)
);
`default_nettype wire

[bench/resp_reply_stream_parser_unit_tb.sv]
`default_nettype none
module resp_reply_stream_parser_unit_tb;

  localparam int unsigned DEPTH_LIM = rrsp_pkg::MAX_DEPTH_DEF;
  localparam logic [63:0] LEN_LIMIT = (64'd1 << rrsp_pkg::LEN_BITS_DEF) - 64'd1;

  typedef struct {
    rrsp_pkg::event_t ev;
    logic [7:0]       pb;
    logic [63:0]      num;
    logic [3:0]       lvl;
    logic             done;
  } reply_event_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
  } stream_byte_t;

  logic clk;
  logic rst_n;

  rrsp_in_if  in_if ();
  rrsp_out_if out_if ();

  resp_reply_stream_parser_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  stream_byte_t stream_q[$];
  reply_event_t event_q[$];
  bit           next_drain;
  int           err_cnt;
  int           byte_total;
  int           event_total;
  bit           in_took;
  bit           out_took;

  // parser shadow state
  rrsp_pkg::phase_t sh_phase;
  rrsp_pkg::kind_t  sh_kind;
  bit               sh_neg;
  logic [63:0]      sh_acc;
  logic [63:0]      sh_slen;
  logic [63:0]      sh_left;
  logic [31:0]      sh_counts[DEPTH_LIM];
  int unsigned      sh_nest;
  bit               sh_err;

  function automatic void clear_elem();
    sh_phase = rrsp_pkg::PH_TYPE;
    sh_neg   = 1'b0;
    sh_acc   = '0;
    sh_slen  = '0;
    sh_left  = '0;
  endfunction

  // pop every array this element completes, 1 if the whole reply is done
  function automatic bit close_elem();
    clear_elem();
    while (sh_nest > 0) begin
      sh_counts[sh_nest-1] = sh_counts[sh_nest-1] - 32'd1;
      if (sh_counts[sh_nest-1] != 0) return 1'b0;
      sh_nest--;
    end
    return 1'b1;
  endfunction

  function automatic void post(rrsp_pkg::event_t ev, logic [7:0] pb, logic [63:0] num,
                               int unsigned lvl, bit done);
    reply_event_t e;
    e.ev   = ev;
    e.pb   = pb;
    e.num  = num;
    e.lvl  = lvl[3:0];
    e.done = done;
    event_q.push_back(e);
  endfunction

  function automatic void proto_fail();
    sh_err = 1'b1;
    post(rrsp_pkg::EV_PROTO_ERR, 8'd0, 64'd0, sh_nest, 1'b0);
  endfunction

  // number line closed by its LF
  function automatic void finish_number();
    int unsigned lvl;
    logic [63:0] cnt;
    bit          d;
    lvl = sh_nest;
    if (sh_kind == rrsp_pkg::K_INT) begin
      cnt = sh_neg ? (64'd0 - sh_acc) : sh_acc;
      d = close_elem();
      post(rrsp_pkg::EV_INTEGER, 8'd0, cnt, lvl, d);
    end else if (sh_kind == rrsp_pkg::K_BULK) begin
      if (sh_neg) begin
        d = close_elem();
        post(rrsp_pkg::EV_NULL_BULK, 8'd0, '1, lvl, d);
      end else begin
        sh_slen  = sh_acc;
        sh_left  = sh_acc + 64'd2;
        sh_phase = rrsp_pkg::PH_BODY;
      end
    end else if (sh_neg) begin
      d = close_elem();
      post(rrsp_pkg::EV_NULL_ARRAY, 8'd0, '1, lvl, d);
    end else if (sh_acc == 0) begin
      d = close_elem();
      post(rrsp_pkg::EV_ARRAY_HDR, 8'd0, 64'd0, lvl, d);
    end else if (sh_nest >= DEPTH_LIM) begin
      proto_fail();
    end else begin
      cnt = sh_acc;
      sh_counts[sh_nest] = cnt[31:0];
      sh_nest++;
      clear_elem();
      post(rrsp_pkg::EV_ARRAY_HDR, 8'd0, cnt, lvl, 1'b0);
    end
  endfunction

  // expected events for one accepted stream byte
  function automatic void parse_byte(logic [7:0] b);
    int unsigned lvl;
    logic [63:0] len;
    logic [63:0] dg;
    bit          d;
    if (sh_err) return;
    case (sh_phase)
      rrsp_pkg::PH_TYPE: begin
        clear_elem();
        case (b)
          rrsp_pkg::CH_PLUS: begin
            sh_kind = rrsp_pkg::K_STATUS; sh_phase = rrsp_pkg::PH_LINE;
          end
          rrsp_pkg::CH_MINUS: begin
            sh_kind = rrsp_pkg::K_ERROR; sh_phase = rrsp_pkg::PH_LINE;
          end
          rrsp_pkg::CH_COLON: begin
            sh_kind = rrsp_pkg::K_INT; sh_phase = rrsp_pkg::PH_NUM;
          end
          rrsp_pkg::CH_DOLL: begin
            sh_kind = rrsp_pkg::K_BULK; sh_phase = rrsp_pkg::PH_NUM;
          end
          rrsp_pkg::CH_STAR: begin
            sh_kind = rrsp_pkg::K_ARRAY; sh_phase = rrsp_pkg::PH_NUM;
          end
          default: proto_fail();
        endcase
      end
      rrsp_pkg::PH_LINE, rrsp_pkg::PH_LINE_CR: begin
        if (sh_phase == rrsp_pkg::PH_LINE && b == rrsp_pkg::CH_CR) begin
          sh_phase = rrsp_pkg::PH_LINE_CR;
        end else if (sh_phase == rrsp_pkg::PH_LINE_CR && b == rrsp_pkg::CH_LF) begin
          lvl = sh_nest;
          len = sh_slen;
          d = close_elem();
          post((sh_kind == rrsp_pkg::K_ERROR) ? rrsp_pkg::EV_ERROR_END
                                              : rrsp_pkg::EV_STATUS_END,
               8'd0, len, lvl, d);
        end else begin
          if (sh_slen < LEN_LIMIT) sh_slen = sh_slen + 64'd1;
          post(rrsp_pkg::EV_PAYLOAD, b, 64'd0, sh_nest, 1'b0);
        end
      end
      rrsp_pkg::PH_NUM, rrsp_pkg::PH_NUM_CR: begin
        if (sh_phase == rrsp_pkg::PH_NUM && b == rrsp_pkg::CH_CR) begin
          sh_phase = rrsp_pkg::PH_NUM_CR;
        end else if (sh_phase == rrsp_pkg::PH_NUM_CR && b == rrsp_pkg::CH_LF) begin
          finish_number();
        end else if (b == rrsp_pkg::CH_MINUS) begin
          sh_neg = 1'b1;
        end else if (b >= rrsp_pkg::CH_ZERO && b <= rrsp_pkg::CH_NINE) begin
          dg = 64'(b - rrsp_pkg::CH_ZERO);
          if (sh_kind != rrsp_pkg::K_INT && sh_acc > (LEN_LIMIT - dg) / 64'd10) proto_fail();
          else sh_acc = sh_acc * 64'd10 + dg;
        end else begin
          proto_fail();
        end
      end
      rrsp_pkg::PH_BODY: begin
        if (sh_left > 2) post(rrsp_pkg::EV_PAYLOAD, b, 64'd0, sh_nest, 1'b0);
        if (sh_left > 0) sh_left = sh_left - 64'd1;
        if (sh_left == 0) begin
          lvl = sh_nest;
          len = sh_slen;
          d = close_elem();
          post(rrsp_pkg::EV_BULK_END, 8'd0, len, lvl, d);
        end
      end
      default: clear_elem();
    endcase
  endfunction

  // stream building
  function automatic void add(logic [7:0] b);
    stream_byte_t s;
    s.b = b;
    s.drain = next_drain;
    next_drain = 1'b0;
    stream_q.push_back(s);
    byte_total++;
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  function automatic void add_crlf();
    add(rrsp_pkg::CH_CR);
    add(rrsp_pkg::CH_LF);
  endfunction

  function automatic void add_line(logic [7:0] t, string s);
    add(t);
    add_str(s);
    add_crlf();
  endfunction

  // status or error line with random text, sometimes bytes between CR and LF
  function automatic void gen_line(logic [7:0] t);
    logic [7:0] c;
    add(t);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(0, 255));
      if (c == rrsp_pkg::CH_CR) c = 8'hff;
      add(c);
    end
    add(rrsp_pkg::CH_CR);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(0, 255));
        if (c == rrsp_pkg::CH_LF) c = rrsp_pkg::CH_CR;
        add(c);
      end
    end
    add(rrsp_pkg::CH_LF);
  endfunction

  function automatic void gen_int();
    int n;
    int split;
    add(rrsp_pkg::CH_COLON);
    n = $urandom_range(0, 3) == 0 ? $urandom_range(15, 21) : $urandom_range(1, 6);
    split = $urandom_range(0, 7) == 0 ? $urandom_range(0, n) : n;
    if ($urandom_range(0, 2) == 0) add(rrsp_pkg::CH_MINUS);
    for (int i = 0; i < n; i++) begin
      if (i == split) add(rrsp_pkg::CH_CR);
      add(rrsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (split == n) add(rrsp_pkg::CH_CR);
    add(rrsp_pkg::CH_LF);
  endfunction

  function automatic void gen_bulk();
    int n;
    n = $urandom_range(0, 6);
    add_line(rrsp_pkg::CH_DOLL, $sformatf("%0d", n));
    repeat (n + 2) add(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_elem(int depth);
    int k;
    int n;
    k = $urandom_range(0, 9);
    if (k >= 7 && depth >= DEPTH_LIM) k = 2;
    case (k)
      0: gen_line(rrsp_pkg::CH_PLUS);
      1: gen_line(rrsp_pkg::CH_MINUS);
      2, 3: gen_int();
      4, 5: gen_bulk();
      6: begin
        if ($urandom_range(0, 1) == 1) add(rrsp_pkg::CH_DOLL);
        else add(rrsp_pkg::CH_STAR);
        if ($urandom_range(0, 1) == 1) add_str("-1");
        else add_str("1-");
        add_crlf();
      end
      default: begin
        n = depth < 3 ? $urandom_range(0, 3) : $urandom_range(0, 1);
        add_line(rrsp_pkg::CH_STAR, $sformatf("%0d", n));
        for (int i = 0; i < n; i++) gen_elem(depth + 1);
      end
    endcase
  endfunction

  // one ending that trips the error latch
  function automatic void gen_error_tail();
    logic [7:0] c;
    next_drain = 1'b1;
    case ($urandom_range(0, 3))
      0: begin
        c = 8'($urandom_range(0, 255));
        if (c == rrsp_pkg::CH_PLUS || c == rrsp_pkg::CH_MINUS || c == rrsp_pkg::CH_COLON ||
            c == rrsp_pkg::CH_DOLL || c == rrsp_pkg::CH_STAR)
          c = rrsp_pkg::CH_LF;
        add(c);
      end
      1: begin
        add_str(":12");
        c = 8'($urandom_range(0, 255));
        if ((c >= rrsp_pkg::CH_ZERO && c <= rrsp_pkg::CH_NINE) || c == rrsp_pkg::CH_MINUS ||
            c == rrsp_pkg::CH_CR)
          c = 8'h78;
        add(c);
      end
      2: add_str("$-4294967296");
      default: begin
        repeat (DEPTH_LIM + 1) add_line(rrsp_pkg::CH_STAR, "1");
      end
    endcase
  endfunction

  // stimulus
  initial begin
    next_drain = 1'b0;
    byte_total = 0;
    add_line(rrsp_pkg::CH_PLUS, "OK");
    add_line(rrsp_pkg::CH_MINUS, "ERR");
    add_line(rrsp_pkg::CH_COLON, "18446744073709551615");
    add_line(rrsp_pkg::CH_COLON, "-9223372036854775808");
    add_line(rrsp_pkg::CH_DOLL, "0");
    add_crlf();
    add_line(rrsp_pkg::CH_DOLL, "-1");
    add_line(rrsp_pkg::CH_STAR, "-1");
    add_line(rrsp_pkg::CH_STAR, "0");
    repeat (DEPTH_LIM) add_line(rrsp_pkg::CH_STAR, "1");
    add_line(rrsp_pkg::CH_COLON, "5");
    while (byte_total < 560) begin
      if (byte_total > 280 && byte_total < 300) next_drain = 1'b1;
      gen_elem(0);
    end
    gen_error_tail();
    // bytes after the error are taken and give nothing
    add_line(rrsp_pkg::CH_PLUS, "OK");
    add_line(rrsp_pkg::CH_COLON, "7");
  end

  // input driver
  int  send_gap;
  bit  send_calm;
  always @(negedge clk) begin
    logic busy;
    if (rst_n) begin
      busy = in_if.valid;
      if (busy && in_took) begin
        in_took = 1'b0;
        busy = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 12);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stream_q.size() > 0 && !(stream_q[0].drain && event_q.size() != 0)) begin
          in_if.in_byte <= stream_q[0].b;
          stream_q.pop_front();
          busy = 1'b1;
        end
      end
      in_if.valid <= busy;
    end
  end

  // result receiver
  int  recv_stall;
  bit  recv_calm;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_took = 1'b0;
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 12);
        if (event_total == 150) recv_stall = 400;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from the accepted byte
  always @(posedge clk) begin
    reply_event_t e;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        out_took = 1'b1;
        event_total++;
        if (event_q.size() == 0) begin
          $display("%0t: unexpected event ev=%0d pb=%h num=%0d lvl=%0d done=%0b", $time,
                   out_if.event_res, out_if.payload_byte, out_if.number, out_if.level,
                   out_if.reply_done);
          err_cnt++;
        end else begin
          e = event_q.pop_front();
          if (out_if.event_res !== e.ev || out_if.payload_byte !== e.pb ||
              out_if.number !== e.num || out_if.level !== e.lvl ||
              out_if.reply_done !== e.done) begin
            $display("%0t: mismatch exp ev=%0d pb=%h num=%0d lvl=%0d done=%0b", $time,
                     e.ev, e.pb, $signed(e.num), e.lvl, e.done);
            $display("%0t:          got ev=%0d pb=%h num=%0d lvl=%0d done=%0b", $time,
                     out_if.event_res, out_if.payload_byte, out_if.number, out_if.level,
                     out_if.reply_done);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_took = 1'b1;
        parse_byte(in_if.in_byte);
      end
    end
  end

  // reset and end of run
  initial begin
    err_cnt       = 0;
    event_total   = 0;
    in_took       = 1'b0;
    out_took      = 1'b0;
    send_gap      = 0;
    send_calm     = 1'b0;
    recv_stall    = 0;
    recv_calm     = 1'b0;
    sh_kind       = rrsp_pkg::K_STATUS;
    sh_nest       = 0;
    sh_err        = 1'b0;
    clear_elem();
    for (int i = 0; i < DEPTH_LIM; i++) sh_counts[i] = '0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'd0;
    out_if.ready  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (stream_q.size() != 0 || in_if.valid) @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && event_q.size() == 0) begin
      $display("resp_reply_stream_parser_unit_tb: done, clean");
    end else begin
      $display("resp_reply_stream_parser_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("resp_reply_stream_parser_unit_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
